// ===== hdl/btn_dbc_pkg.sv =====
`timescale 1ns / 1ps

package btn_dbc_pkg;

   // event codes carried on the result channel
   typedef enum logic [2:0] {
      EV_NONE   = 3'd0,
      EV_SINGLE = 3'd1,
      EV_DOUBLE = 3'd2,
      EV_TRIPLE = 3'd3,
      EV_HOLD   = 3'd4
   } event_type;

   // configuration register indexes
   localparam logic [1:0] CSR_ACTIVE_LOW  = 2'd0;
   localparam logic [1:0] CSR_HOLD_TARGET = 2'd1;
   localparam logic [1:0] CSR_MIN_PRESS   = 2'd2;
   localparam logic [1:0] CSR_CLICK_GAP   = 2'd3;

   // request kinds
   localparam logic REQ_SAMPLE = 1'b0;
   localparam logic REQ_TICK   = 1'b1;

   // reset values of the configuration registers
   localparam logic        ACTIVE_LOW_RESET  = 1'b1;
   localparam logic [31:0] HOLD_TARGET_RESET = 32'd1000;
   localparam logic [15:0] MIN_PRESS_RESET   = 16'd50;
   localparam logic [15:0] CLICK_GAP_RESET   = 16'd300;

   localparam logic [2:0] TALLY_MAX = 3'd7;

   typedef struct packed {
      logic [31:0] hold_target;
      logic [15:0] min_press;
      logic [15:0] click_gap;
   } timing_cfg_type;

   // event machine state, history register excluded
   typedef struct packed {
      logic        debounced;
      logic        previous;
      logic [31:0] press_start;
      logic [31:0] last_release;
      logic [2:0]  tally;
      logic        hold_done;
   } machine_state_type;

endpackage

// ===== hdl/btn_dbc_event_logic.sv =====
`timescale 1ns / 1ps

module btn_dbc_event_logic
   import btn_dbc_pkg::*;
(
   input  machine_state_type state_cur,
   input  timing_cfg_type    timing_cfg,
   input  logic [31:0]       now_ms,
   output machine_state_type state_next,
   output event_type         event_out
);

   logic        rise;
   logic [31:0] start_time;
   logic        hold_clear;
   logic [31:0] press_age;
   logic        hold_fire;
   logic        hold_set;
   logic [2:0]  tally_after_hold;
   logic        click;
   logic [2:0]  tally_after_click;
   logic [31:0] release_time;
   logic [31:0] quiet_age;
   logic        burst_end;

   always_comb begin
      // press edge restarts the timer
      rise       = state_cur.debounced && !state_cur.previous;
      start_time = rise ? now_ms : state_cur.press_start;
      hold_clear = rise ? 1'b0 : state_cur.hold_done;
      press_age  = now_ms - start_time;

      // long press fires once and drops any counted clicks
      hold_fire        = state_cur.debounced && !hold_clear &&
                         (press_age >= timing_cfg.hold_target);
      hold_set         = hold_fire | hold_clear;
      tally_after_hold = hold_fire ? 3'd0 : state_cur.tally;

      // release of a press long enough to count
      click = !state_cur.debounced && state_cur.previous && !hold_set &&
              (press_age >= {16'd0, timing_cfg.min_press});
      if (click) begin
         tally_after_click = (tally_after_hold == TALLY_MAX) ? TALLY_MAX
                                                             : tally_after_hold + 3'd1;
         release_time      = now_ms;
      end else begin
         tally_after_click = tally_after_hold;
         release_time      = state_cur.last_release;
      end

      // quiet gap closes the burst
      quiet_age = now_ms - release_time;
      burst_end = !state_cur.debounced && (tally_after_click != 3'd0) &&
                  (quiet_age >= {16'd0, timing_cfg.click_gap});

      event_out = hold_fire ? EV_HOLD : EV_NONE;
      if (burst_end) begin
         case (tally_after_click)
            3'd1:    event_out = EV_SINGLE;
            3'd2:    event_out = EV_DOUBLE;
            3'd3:    event_out = EV_TRIPLE;
            default: event_out = EV_NONE;
         endcase
      end

      state_next.debounced    = state_cur.debounced;
      state_next.previous     = state_cur.debounced;
      state_next.press_start  = start_time;
      state_next.last_release = release_time;
      state_next.tally        = burst_end ? 3'd0 : tally_after_click;
      state_next.hold_done    = hold_set;
   end

endmodule

// ===== hdl/button_debounce_click_hold_detector_unit.sv =====
`timescale 1ns / 1ps

// Button debouncer with multi-click and long-press detection. A request beat with
// req_type 0 shifts the polarity-corrected pin level into a HISTORY_LEN-deep
// history; HISTORY_LEN equal samples set or clear the debounced pressed flag. A
// request beat with req_type 1 carries the millisecond time and steps the event
// machine: HOLD once per long press, SINGLE/DOUBLE/TRIPLE after a quiet gap,
// nothing for four or more clicks. Every request gives exactly one response beat.
// Throughput is one beat per clock when nothing stalls: the input register and
// the response register form a two-stage pipe, and the whole update is one
// combinational pass between them, so a response beat is offered from the
// response register once its request beat has left the input register.
// rsp_stall holds the pipe and reaches req_stall only when the input register is
// full. Configuration writes take effect on the next clock and are meant to be
// made with the pipe empty.
module button_debounce_click_hold_detector_unit
   import btn_dbc_pkg::*;
#(
   parameter int HISTORY_LEN = 8
) (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_type,
   input  logic        req_pin_level,
   input  logic [31:0] req_now_ms,
   // response channel
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_event_code,
   output logic        rsp_pressed_now,
   // configuration writes
   input  logic        csr_write,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_wdata
);

   // configuration
   logic           active_low_ff;
   timing_cfg_type timing_cfg_ff;

   // input stage
   logic        in_valid_ff;
   logic        in_type_ff;
   logic        in_pin_ff;
   logic [31:0] in_now_ff;

   // block state
   logic [HISTORY_LEN-1:0] history_ff;
   logic [HISTORY_LEN-1:0] history_in;
   machine_state_type      machine_ff;
   machine_state_type      machine_in;
   machine_state_type      machine_tick;
   event_type              tick_event;

   // response stage
   logic       rsp_valid_ff;
   logic [2:0] rsp_event_ff;
   logic       rsp_pressed_ff;

   logic out_free;
   logic advance;
   logic take_req;
   logic event_valid_in;
   logic [2:0] event_in;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign advance   = in_valid_ff && out_free;
   assign req_stall = in_valid_ff && !out_free;
   assign take_req  = req_valid && !req_stall;

   btn_dbc_event_logic u_event (
      .state_cur  (machine_ff),
      .timing_cfg (timing_cfg_ff),
      .now_ms     (in_now_ff),
      .state_next (machine_tick),
      .event_out  (tick_event)
   );

   // next state for the beat in the input stage
   always_comb begin
      history_in = history_ff;
      machine_in = machine_ff;
      event_in   = EV_NONE;
      if (in_type_ff == REQ_SAMPLE) begin
         // pressed bit is the pin level flipped for active-low wiring
         history_in = {history_ff[HISTORY_LEN-2:0], in_pin_ff ^ active_low_ff};
         if (history_in == '1) begin
            machine_in.debounced = 1'b1;
         end else if (history_in == '0) begin
            machine_in.debounced = 1'b0;
         end
      end else begin
         machine_in = machine_tick;
         event_in   = tick_event;
      end
      event_valid_in = in_valid_ff;
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         active_low_ff             <= ACTIVE_LOW_RESET;
         timing_cfg_ff.hold_target <= HOLD_TARGET_RESET;
         timing_cfg_ff.min_press   <= MIN_PRESS_RESET;
         timing_cfg_ff.click_gap   <= CLICK_GAP_RESET;
      end else if (csr_write) begin
         case (csr_index)
            CSR_ACTIVE_LOW:  active_low_ff             <= csr_wdata[0];
            CSR_HOLD_TARGET: timing_cfg_ff.hold_target <= csr_wdata;
            CSR_MIN_PRESS:   timing_cfg_ff.min_press   <= csr_wdata[15:0];
            CSR_CLICK_GAP:   timing_cfg_ff.click_gap   <= csr_wdata[15:0];
            default:         active_low_ff             <= active_low_ff;
         endcase
      end
   end

   // input stage control
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         in_valid_ff <= req_valid;
      end
   end

   // input stage payload
   always_ff @(posedge clock) begin
      if (take_req) begin
         in_type_ff <= req_type;
         in_pin_ff  <= req_pin_level;
         in_now_ff  <= req_now_ms;
      end
   end

   // block state moves only when a beat leaves the input stage
   always_ff @(posedge clock) begin
      if (reset) begin
         history_ff <= '0;
         machine_ff <= '0;
      end else if (advance) begin
         history_ff <= history_in;
         machine_ff <= machine_in;
      end
   end

   // response stage control
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= event_valid_in;
      end
   end

   // response stage payload
   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_event_ff   <= event_in;
         rsp_pressed_ff <= machine_in.debounced;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_event_code  = rsp_event_ff;
   assign rsp_pressed_now = rsp_pressed_ff;

endmodule

// ===== hdl/btn_dbc_checker.sv =====
`timescale 1ns / 1ps

module btn_dbc_checker
   import btn_dbc_pkg::*;
(
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [2:0] rsp_event_code,
   input logic       rsp_pressed_now
);

   // no response beat right after reset
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid right after reset");

   // held response keeps its payload
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_event_code) &&
                                 $stable(rsp_pressed_now))
      else $error("stalled response changed");

   // a hold only fires while the button is down
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_event_code == EV_HOLD) |-> rsp_pressed_now)
      else $error("hold event with button released");

   // a click burst only ends while the button is up
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_event_code == EV_SINGLE || rsp_event_code == EV_DOUBLE ||
                    rsp_event_code == EV_TRIPLE) |-> !rsp_pressed_now)
      else $error("click event with button pressed");

endmodule

bind button_debounce_click_hold_detector_unit btn_dbc_checker u_checker (.*);

// ===== tb/button_event_monitor.sv =====
`timescale 1ns / 1ps

module button_event_monitor
   import btn_dbc_pkg::*;
#(
   parameter int HISTORY_LEN = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic        req_type,
   input  logic        req_pin_level,
   input  logic [31:0] req_now_ms,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic [2:0]  rsp_event_code,
   input  logic        rsp_pressed_now,
   input  logic        csr_write,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_wdata,
   output int          fail_count,
   output int          pending_count
);

   typedef struct packed {
      event_type code;
      logic      pressed;
   } click_result_type;

   logic                   active_low_cfg;
   timing_cfg_type         timing;
   logic [HISTORY_LEN-1:0] history;
   machine_state_type      machine;

   click_result_type expected_events[$];
   click_result_type predicted;
   click_result_type oldest;

   function automatic click_result_type step_button(input logic kind, input logic pin,
                                                    input logic [31:0] now);
      logic [31:0]      held_for;
      logic [31:0]      quiet_for;
      logic             level_pressed;
      click_result_type res;
      res.code = EV_NONE;
      if (kind == REQ_SAMPLE) begin
         level_pressed = active_low_cfg ? (pin == 1'b0) : (pin == 1'b1);
         history = {history[HISTORY_LEN-2:0], level_pressed};
         if (&history) begin
            machine.debounced = 1'b1;
         end else if (history == '0) begin
            machine.debounced = 1'b0;
         end
      end else begin
         if (machine.debounced && !machine.previous) begin
            machine.press_start = now;
            machine.hold_done = 1'b0;
         end
         held_for = now - machine.press_start;
         if (machine.debounced && !machine.hold_done && held_for >= timing.hold_target) begin
            res.code = EV_HOLD;
            machine.hold_done = 1'b1;
            machine.tally = '0;
         end
         if (!machine.debounced && machine.previous && !machine.hold_done &&
             held_for >= {16'd0, timing.min_press}) begin
            if (machine.tally != TALLY_MAX) begin
               machine.tally = machine.tally + 3'd1;
            end
            machine.last_release = now;
         end
         quiet_for = now - machine.last_release;
         if (!machine.debounced && machine.tally != '0 &&
             quiet_for >= {16'd0, timing.click_gap}) begin
            case (machine.tally)
               3'd1: res.code = EV_SINGLE;
               3'd2: res.code = EV_DOUBLE;
               3'd3: res.code = EV_TRIPLE;
               default: res.code = EV_NONE;
            endcase
            machine.tally = '0;
         end
         machine.previous = machine.debounced;
      end
      res.pressed = machine.debounced;
      return res;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         active_low_cfg = ACTIVE_LOW_RESET;
         timing = '{hold_target: HOLD_TARGET_RESET, min_press: MIN_PRESS_RESET,
                    click_gap: CLICK_GAP_RESET};
         history = '0;
         machine = '0;
         expected_events.delete();
         fail_count = 0;
      end else begin
         if (csr_write) begin
            case (csr_index)
               CSR_ACTIVE_LOW:  active_low_cfg = csr_wdata[0];
               CSR_HOLD_TARGET: timing.hold_target = csr_wdata;
               CSR_MIN_PRESS:   timing.min_press = csr_wdata[15:0];
               CSR_CLICK_GAP:   timing.click_gap = csr_wdata[15:0];
               default: ;
            endcase
         end
         // request first so a same-edge response still finds its entry
         if (req_valid && !req_stall) begin
            predicted = step_button(req_type, req_pin_level, req_now_ms);
            expected_events.push_back(predicted);
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_events.size() == 0) begin
               $error("unexpected response beat: event_code %0d pressed_now %0b",
                      rsp_event_code, rsp_pressed_now);
               fail_count++;
            end else begin
               oldest = expected_events.pop_front();
               if (rsp_event_code !== oldest.code) begin
                  $error("event_code mismatch: expected %0d, got %0d",
                         oldest.code, rsp_event_code);
                  fail_count++;
               end
               if (rsp_pressed_now !== oldest.pressed) begin
                  $error("pressed_now mismatch: expected %0b, got %0b",
                         oldest.pressed, rsp_pressed_now);
                  fail_count++;
               end
            end
         end
      end
      pending_count = expected_events.size();
   end

endmodule

// ===== tb/button_debounce_click_hold_detector_unit_test.sv =====
`timescale 1ns / 1ps

module button_debounce_click_hold_detector_unit_test;
   import btn_dbc_pkg::*;

   localparam int HISTORY_LEN  = 8;
   localparam int CYCLE_LIMIT  = 200000;
   // two-stage pipe, plus some slack
   localparam int DRAIN_CYCLES = 4;

   typedef enum {STALL_NEVER, STALL_SOMETIMES, STALL_MOSTLY} stall_mode_type;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic        req_type;
   logic        req_pin_level;
   logic [31:0] req_now_ms;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [2:0]  rsp_event_code;
   logic        rsp_pressed_now;
   logic        csr_write;
   logic [1:0]  csr_index;
   logic [31:0] csr_wdata;

   int fail_count;
   int pending_count;
   int cycle_count = 0;
   int items_sent = 0;
   int burst_left = 0;

   stall_mode_type stall_mode = STALL_NEVER;
   int             stall_left = 0;

   // stimulus view of the time base and of the registers last written
   logic [31:0] wall_ms;
   logic        cfg_active_low;
   logic [31:0] cfg_hold_target;
   logic [15:0] cfg_min_press;
   logic [15:0] cfg_click_gap;

   always #6 clock = ~clock;

   button_debounce_click_hold_detector_unit #(
      .HISTORY_LEN (HISTORY_LEN)
   ) DUT (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_type        (req_type),
      .req_pin_level   (req_pin_level),
      .req_now_ms      (req_now_ms),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_event_code  (rsp_event_code),
      .rsp_pressed_now (rsp_pressed_now),
      .csr_write       (csr_write),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   button_event_monitor #(
      .HISTORY_LEN (HISTORY_LEN)
   ) u_events (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_type        (req_type),
      .req_pin_level   (req_pin_level),
      .req_now_ms      (req_now_ms),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_event_code  (rsp_event_code),
      .rsp_pressed_now (rsp_pressed_now),
      .csr_write       (csr_write),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .fail_count      (fail_count),
      .pending_count   (pending_count)
   );

   // receiver backpressure: modes that last a while, from never stalling to stalling
   // three beats in four
   always @(posedge clock) begin
      if (stall_left == 0) begin
         stall_mode <= stall_mode_type'($urandom_range(2));
         stall_left <= $urandom_range(20, 200);
      end else begin
         stall_left <= stall_left - 1;
      end
      case (stall_mode)
         STALL_NEVER:     rsp_stall <= 1'b0;
         STALL_SOMETIMES: rsp_stall <= ($urandom_range(3) == 0);
         default:         rsp_stall <= ($urandom_range(3) != 0);
      endcase
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // one request beat; bursts of random length, mostly with idle gaps between them
   task automatic send_beat(input logic kind, input logic pin, input logic [31:0] stamp);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 48);
      end
      burst_left--;
      req_valid     <= 1'b1;
      req_type      <= kind;
      req_pin_level <= pin;
      req_now_ms    <= stamp;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      items_sent++;
   endtask

   // process tick, the pin field is don't-care
   task automatic tick(input logic [31:0] stamp);
      send_beat(REQ_TICK, 1'($urandom_range(1)), stamp);
   endtask

   // hold off until every response is back and the pipe is empty
   task automatic wait_for_results();
      req_valid <= 1'b0;
      @(negedge clock);
      while (pending_count != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // all four registers back to back, write enable held across them
   task automatic set_timing(input logic [31:0] al_word, input logic [31:0] hold_word,
                             input logic [31:0] min_word, input logic [31:0] gap_word);
      wait_for_results();
      csr_write <= 1'b1;
      csr_index <= CSR_ACTIVE_LOW;
      csr_wdata <= al_word;
      @(posedge clock);
      csr_index <= CSR_HOLD_TARGET;
      csr_wdata <= hold_word;
      @(posedge clock);
      csr_index <= CSR_MIN_PRESS;
      csr_wdata <= min_word;
      @(posedge clock);
      csr_index <= CSR_CLICK_GAP;
      csr_wdata <= gap_word;
      @(posedge clock);
      csr_write <= 1'b0;
      // block keeps the whole hold target and only the low bits of the other registers
      cfg_active_low  = al_word[0];
      cfg_hold_target = hold_word;
      cfg_min_press   = min_word[15:0];
      cfg_click_gap   = gap_word[15:0];
   endtask

   // some contact bounce, then enough steady samples to flip the debounced flag
   task automatic settle(input logic pressed);
      repeat ($urandom_range(0, 3)) send_beat(REQ_SAMPLE, 1'($urandom_range(1)), $urandom);
      repeat (HISTORY_LEN + $urandom_range(0, 2))
         send_beat(REQ_SAMPLE, pressed ^ cfg_active_low, $urandom);
   endtask

   // press durations around the interesting boundaries
   function automatic logic [31:0] press_ms();
      logic [31:0] shortest;
      shortest = {16'd0, cfg_min_press};
      case ($urandom_range(7))
         0: return 32'd0;
         1: return shortest - 32'd1;
         2: return shortest;
         3: return cfg_hold_target - 32'd1 + $urandom_range(0, 2);
         default: return shortest + $urandom_range(0, 200);
      endcase
   endfunction

   // one press and release, with ticks at press edge, optionally partway and at the end, and after release
   task automatic press_for(input logic [31:0] dur);
      settle(1'b1);
      tick(wall_ms);
      if ($urandom_range(3) == 0) tick(wall_ms + (dur >> 1));
      wall_ms += dur;
      // still held here, so a hold can fire
      if ($urandom_range(3) != 0) tick(wall_ms);
      settle(1'b0);
      tick(wall_ms);
   endtask

   // a run of clicks with short gaps, closed by a quiet gap
   task automatic click_burst(input int clicks);
      for (int i = 0; i < clicks; i++) begin
         press_for(press_ms());
         if (i < clicks - 1) begin
            wall_ms += (cfg_click_gap == 16'd0) ? 32'd0 :
                       32'($urandom_range(0, cfg_click_gap - 16'd1));
            if ($urandom_range(2) == 0) tick(wall_ms);
         end
      end
      // land just short of the gap once in a while, then on it
      if (cfg_click_gap != 16'd0 && $urandom_range(1) == 1) begin
         wall_ms += {16'd0, cfg_click_gap} - 32'd1;
         tick(wall_ms);
         wall_ms += 32'd1;
      end else begin
         wall_ms += {16'd0, cfg_click_gap};
      end
      tick(wall_ms);
      if ($urandom_range(1) == 1) begin
         wall_ms += $urandom_range(1, 30);
         tick(wall_ms);
      end
   endtask

   // mostly well-formed clicking and holding, some raw noise, an occasional drain
   task automatic run_phase(input int goal);
      int pick;
      while (items_sent < goal) begin
         pick = $urandom_range(19);
         if (pick == 0) begin
            wait_for_results();
         end else if (pick <= 3) begin
            repeat ($urandom_range(1, 6))
               send_beat(1'($urandom_range(1)), 1'($urandom_range(1)), $urandom);
         end else if (pick <= 6) begin
            press_for(cfg_hold_target - 32'd1 + $urandom_range(0, 4));
         end else begin
            click_burst(($urandom_range(4) == 0) ? $urandom_range(5, 9) : $urandom_range(1, 4));
         end
      end
   endtask

   initial begin
      reset         <= 1'b1;
      req_valid     <= 1'b0;
      req_type      <= REQ_SAMPLE;
      req_pin_level <= 1'b0;
      req_now_ms    <= 32'd0;
      csr_write     <= 1'b0;
      csr_index     <= CSR_ACTIVE_LOW;
      csr_wdata     <= 32'd0;
      cfg_active_low  = ACTIVE_LOW_RESET;
      cfg_hold_target = HOLD_TARGET_RESET;
      cfg_min_press   = MIN_PRESS_RESET;
      cfg_click_gap   = CLICK_GAP_RESET;
      wall_ms         = 32'd0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // directed, reset settings: time extremes, debounce both ways, hold across the
      // time wrap, release after a hold counts no click
      tick(32'd0);
      tick(32'hFFFF_FFFF);
      send_beat(REQ_SAMPLE, 1'b1, 32'hFFFF_FFFF);
      repeat (HISTORY_LEN) send_beat(REQ_SAMPLE, 1'b0, 32'd0);
      tick(32'hFFFF_FFF0);
      // wrapped difference of exactly the reset hold target
      tick(32'h0000_03D8);
      repeat (HISTORY_LEN) send_beat(REQ_SAMPLE, 1'b1, 32'hFFFF_FFFF);
      tick(32'h0000_0400);

      wall_ms = 32'h0000_0800;
      run_phase(items_sent + 200);

      // active high, zero hold, zero min press, zero gap; high write bits masked off
      set_timing(32'h0000_0000, 32'h0000_0000, 32'hABCD_0000, 32'h0001_0000);
      wall_ms = 32'hFFFF_FF00;
      run_phase(items_sent + 200);

      // active low, largest hold target, widest press and gap: tally saturation
      set_timing(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h5A5A_FFFF, 32'hFFFF_FFFF);
      wall_ms = $urandom;
      click_burst(9);
      run_phase(items_sent + 300);

      // moderate random settings; four clicks end with no event
      set_timing($urandom, $urandom_range(200, 3000),
                 ($urandom & 32'hFFFF_0000) | $urandom_range(0, 100),
                 ($urandom & 32'hFFFF_0000) | $urandom_range(50, 400));
      wall_ms = $urandom;
      click_burst(4);
      run_phase(items_sent + 200);

      wait_for_results();
      if (fail_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
